@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked implication checks, disabled while the active-low reset is asserted.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/pdc_pkg.sv @@
// ----------------------------------------------------------------------------
// pdc_pkg
// Shared types, constants and helpers of the differential drive PID unit.
// ----------------------------------------------------------------------------
package pdc_pkg;

    localparam int GAIN_FRAC_BITS = 8;
    localparam int SPEED_MAX      = 255;

    localparam int GAIN_W     = 16;
    localparam int POS_W      = 16;
    localparam int CNT_W      = 32;
    localparam int SPEED_W    = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // products and their sum
    localparam int PROD_W  = GAIN_W + 1 + CNT_W;      // gain * error / integral
    localparam int PRODD_W = GAIN_W + 1 + CNT_W + 1;  // gain * derivative
    localparam int SUM_W   = PRODD_W + 2;
    localparam int CORR_W  = SUM_W - GAIN_FRAC_BITS;

    localparam int NUM_STAGES = 6;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] IDX_FWD_KP      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] IDX_FWD_KI      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] IDX_FWD_KD      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] IDX_BWD_KP      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] IDX_BWD_KI      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] IDX_BWD_KD      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] IDX_BASE_SPEED  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] IDX_LINE_CENTER = 3'd7;

    // tick modes
    localparam logic OP_FWD = 1'b0;
    localparam logic OP_BWD = 1'b1;

    typedef struct packed {
        logic [GAIN_W-1:0]  fwd_kp;
        logic [GAIN_W-1:0]  fwd_ki;
        logic [GAIN_W-1:0]  fwd_kd;
        logic [GAIN_W-1:0]  bwd_kp;
        logic [GAIN_W-1:0]  bwd_ki;
        logic [GAIN_W-1:0]  bwd_kd;
        logic [SPEED_W-1:0] base_speed;
        logic [POS_W-1:0]   line_center;
    } t_cfg;

    typedef struct packed {
        logic [NUM_STAGES-1:0] valid;
        logic [NUM_STAGES-1:0] load;
    } t_pipe_ctl;

    typedef struct packed {
        logic                    op;
        logic signed [CNT_W-1:0] err;
        logic signed [CNT_W-1:0] acc;
        logic signed [CNT_W:0]   deriv;
    } t_terms;

    // saturate a 33-bit signed value to 32 bits
    function automatic logic signed [CNT_W-1:0] sat32(input logic signed [CNT_W:0] v);
        logic signed [CNT_W-1:0] res;
        if (v[CNT_W] != v[CNT_W-1]) begin
            res = v[CNT_W] ? {1'b1, {(CNT_W-1){1'b0}}} : {1'b0, {(CNT_W-1){1'b1}}};
        end else begin
            res = v[CNT_W-1:0];
        end
        return res;
    endfunction

endpackage

@@ rtl/pdc_in_if.sv @@
// ----------------------------------------------------------------------------
// pdc_in_if
// Control tick channel: mode, line position and both encoder counts.
// ----------------------------------------------------------------------------
interface pdc_in_if;
    logic               valid;
    logic               ready;
    logic               op;
    logic [15:0]        position;
    logic signed [31:0] left_count;
    logic signed [31:0] right_count;

    modport source (output valid, op, position, left_count, right_count, input ready);
    modport sink   (input valid, op, position, left_count, right_count, output ready);
endinterface

@@ rtl/pdc_out_if.sv @@
// ----------------------------------------------------------------------------
// pdc_out_if
// Speed command channel: clamped left and right motor speeds.
// ----------------------------------------------------------------------------
interface pdc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] left_speed;
    logic [7:0] right_speed;

    modport source (output valid, left_speed, right_speed, input ready);
    modport sink   (input valid, left_speed, right_speed, output ready);
endinterface

@@ rtl/pdc_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// pdc_cfg_regs
// Gain, base speed and line center registers behind a plain write port.
// ----------------------------------------------------------------------------
module pdc_cfg_regs (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [pdc_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [pdc_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output pdc_pkg::t_cfg                    o_cfg
);
    import pdc_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.fwd_kp      <= 16'd256;
            r_cfg.fwd_ki      <= 16'd0;
            r_cfg.fwd_kd      <= 16'd179;
            r_cfg.bwd_kp      <= 16'd307;
            r_cfg.bwd_ki      <= 16'd0;
            r_cfg.bwd_kd      <= 16'd154;
            r_cfg.base_speed  <= 8'd180;
            r_cfg.line_center <= 16'd3500;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                IDX_FWD_KP:      r_cfg.fwd_kp      <= i_cfg_data;
                IDX_FWD_KI:      r_cfg.fwd_ki      <= i_cfg_data;
                IDX_FWD_KD:      r_cfg.fwd_kd      <= i_cfg_data;
                IDX_BWD_KP:      r_cfg.bwd_kp      <= i_cfg_data;
                IDX_BWD_KI:      r_cfg.bwd_ki      <= i_cfg_data;
                IDX_BWD_KD:      r_cfg.bwd_kd      <= i_cfg_data;
                IDX_BASE_SPEED:  r_cfg.base_speed  <= i_cfg_data[SPEED_W-1:0];
                IDX_LINE_CENTER: r_cfg.line_center <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;
endmodule

@@ rtl/pdc_pipe_ctrl.sv @@
// ----------------------------------------------------------------------------
// pdc_pipe_ctrl
// Valid bits and load enables of the stage pipeline; bubbles collapse.
// ----------------------------------------------------------------------------
module pdc_pipe_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_out_ready,
    output logic                 o_in_ready,
    output pdc_pkg::t_pipe_ctl   o_ctl
);
    import pdc_pkg::*;

    logic [NUM_STAGES-1:0] r_valid;
    logic [NUM_STAGES-1:0] n_valid;
    logic [NUM_STAGES-1:0] w_ready;
    logic [NUM_STAGES-1:0] w_vin;

    always_comb begin
        w_ready[NUM_STAGES-1] = !r_valid[NUM_STAGES-1] || i_out_ready;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            w_ready[k] = !r_valid[k] || w_ready[k+1];
        end
        w_vin   = {r_valid[NUM_STAGES-2:0], i_in_valid};
        n_valid = (w_ready & w_vin) | (~w_ready & r_valid);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= n_valid;
        end
    end

    assign o_in_ready  = w_ready[0];
    assign o_ctl.valid = r_valid;
    assign o_ctl.load  = w_ready & w_vin;
endmodule

@@ rtl/pdc_front.sv @@
// ----------------------------------------------------------------------------
// pdc_front
// Input register, error stage and per-mode integral and last-error state.
// ----------------------------------------------------------------------------
module pdc_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  pdc_pkg::t_pipe_ctl                i_ctl,
    input  pdc_pkg::t_cfg                     i_cfg,
    input  logic                              i_op,
    input  logic [pdc_pkg::POS_W-1:0]         i_position,
    input  logic signed [pdc_pkg::CNT_W-1:0]  i_left_count,
    input  logic signed [pdc_pkg::CNT_W-1:0]  i_right_count,
    output pdc_pkg::t_terms                   o_terms
);
    import pdc_pkg::*;

    // input register
    logic                    r_op0;
    logic [POS_W-1:0]        r_pos0;
    logic signed [CNT_W-1:0] r_left0;
    logic signed [CNT_W-1:0] r_right0;

    // error register
    logic                    r_op1;
    logic signed [CNT_W-1:0] r_err1;
    logic signed [CNT_W-1:0] n_err1;
    logic signed [CNT_W:0]   w_cnt_diff;

    // mode state
    logic signed [CNT_W-1:0] r_fwd_accum;
    logic signed [CNT_W-1:0] r_fwd_prev;
    logic signed [CNT_W-1:0] r_bwd_accum;
    logic signed [CNT_W-1:0] r_bwd_prev;
    logic signed [CNT_W-1:0] w_acc_old;
    logic signed [CNT_W-1:0] w_prev_old;
    logic signed [CNT_W-1:0] n_acc;
    logic signed [CNT_W:0]   n_deriv;

    t_terms r_terms;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[0]) begin
            r_op0    <= i_op;
            r_pos0   <= i_position;
            r_left0  <= i_left_count;
            r_right0 <= i_right_count;
        end
    end

    always_comb begin
        w_cnt_diff = {r_left0[CNT_W-1], r_left0} - {r_right0[CNT_W-1], r_right0};
        if (r_op0 == OP_FWD) begin
            n_err1 = $signed({{(CNT_W-POS_W){1'b0}}, r_pos0})
                   - $signed({{(CNT_W-POS_W){1'b0}}, i_cfg.line_center});
        end else begin
            n_err1 = sat32(w_cnt_diff);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[1]) begin
            r_op1  <= r_op0;
            r_err1 <= n_err1;
        end
    end

    always_comb begin
        w_acc_old  = (r_op1 == OP_FWD) ? r_fwd_accum : r_bwd_accum;
        w_prev_old = (r_op1 == OP_FWD) ? r_fwd_prev  : r_bwd_prev;
        n_acc      = sat32({w_acc_old[CNT_W-1], w_acc_old} + {r_err1[CNT_W-1], r_err1});
        n_deriv    = {r_err1[CNT_W-1], r_err1} - {w_prev_old[CNT_W-1], w_prev_old};
    end

    // the state advances exactly when an item leaves the error register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_accum <= '0;
            r_fwd_prev  <= '0;
            r_bwd_accum <= '0;
            r_bwd_prev  <= '0;
        end else if (i_ctl.load[2]) begin
            if (r_op1 == OP_FWD) begin
                r_fwd_accum <= n_acc;
                r_fwd_prev  <= r_err1;
            end else begin
                r_bwd_accum <= n_acc;
                r_bwd_prev  <= r_err1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[2]) begin
            r_terms.op    <= r_op1;
            r_terms.err   <= r_err1;
            r_terms.acc   <= n_acc;
            r_terms.deriv <= n_deriv;
        end
    end

    assign o_terms = r_terms;
endmodule

@@ rtl/pdc_back.sv @@
// ----------------------------------------------------------------------------
// pdc_back
// Gain products, truncated correction and clamped speed result register.
// ----------------------------------------------------------------------------
module pdc_back (
    input  logic                          i_clk,
    input  pdc_pkg::t_pipe_ctl            i_ctl,
    input  pdc_pkg::t_cfg                 i_cfg,
    input  pdc_pkg::t_terms               i_terms,
    output logic [pdc_pkg::SPEED_W-1:0]   o_left_speed,
    output logic [pdc_pkg::SPEED_W-1:0]   o_right_speed
);
    import pdc_pkg::*;

    localparam int SPD_W = CORR_W + 1;
    localparam logic signed [SPD_W-1:0] SPEED_MAX_S = SPD_W'(SPEED_MAX);
    localparam logic signed [SUM_W-1:0] ROUND_BIAS  = SUM_W'((1 << GAIN_FRAC_BITS) - 1);

    // product stage
    logic [GAIN_W-1:0]         w_kp;
    logic [GAIN_W-1:0]         w_ki;
    logic [GAIN_W-1:0]         w_kd;
    logic signed [PROD_W-1:0]  n_prod_p;
    logic signed [PROD_W-1:0]  n_prod_i;
    logic signed [PRODD_W-1:0] n_prod_d;
    logic                      r_op3;
    logic signed [PROD_W-1:0]  r_prod_p;
    logic signed [PROD_W-1:0]  r_prod_i;
    logic signed [PRODD_W-1:0] r_prod_d;

    // correction stage
    logic signed [SUM_W-1:0]   w_sum;
    logic signed [SUM_W-1:0]   w_biased;
    logic signed [SUM_W-1:0]   w_shifted;
    logic                      r_op4;
    logic signed [CORR_W-1:0]  r_corr;

    // speed stage
    logic signed [SPD_W-1:0]   w_base;
    logic signed [SPD_W-1:0]   w_corr;
    logic signed [SPD_W-1:0]   w_left;
    logic signed [SPD_W-1:0]   w_right;
    logic [SPEED_W-1:0]        r_left;
    logic [SPEED_W-1:0]        r_right;

    function automatic logic [SPEED_W-1:0] clamp_speed(input logic signed [SPD_W-1:0] v);
        logic [SPEED_W-1:0] res;
        if (v < 0) begin
            res = '0;
        end else if (v > SPEED_MAX_S) begin
            res = SPEED_MAX_S[SPEED_W-1:0];
        end else begin
            res = v[SPEED_W-1:0];
        end
        return res;
    endfunction

    always_comb begin
        w_kp     = (i_terms.op == OP_FWD) ? i_cfg.fwd_kp : i_cfg.bwd_kp;
        w_ki     = (i_terms.op == OP_FWD) ? i_cfg.fwd_ki : i_cfg.bwd_ki;
        w_kd     = (i_terms.op == OP_FWD) ? i_cfg.fwd_kd : i_cfg.bwd_kd;
        n_prod_p = $signed({1'b0, w_kp}) * i_terms.err;
        n_prod_i = $signed({1'b0, w_ki}) * i_terms.acc;
        n_prod_d = $signed({1'b0, w_kd}) * i_terms.deriv;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[3]) begin
            r_op3    <= i_terms.op;
            r_prod_p <= n_prod_p;
            r_prod_i <= n_prod_i;
            r_prod_d <= n_prod_d;
        end
    end

    // sum, then shift with a bias on negatives so the result rounds toward zero
    always_comb begin
        w_sum     = SUM_W'(r_prod_p) + SUM_W'(r_prod_i) + SUM_W'(r_prod_d);
        w_biased  = w_sum[SUM_W-1] ? (w_sum + ROUND_BIAS) : w_sum;
        w_shifted = w_biased >>> GAIN_FRAC_BITS;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[4]) begin
            r_op4  <= r_op3;
            r_corr <= w_shifted[CORR_W-1:0];
        end
    end

    always_comb begin
        w_base = $signed({{(SPD_W-SPEED_W){1'b0}}, i_cfg.base_speed});
        w_corr = SPD_W'(r_corr);
        if (r_op4 == OP_FWD) begin
            w_left  = w_base + w_corr;
            w_right = w_base - w_corr;
        end else begin
            w_left  = w_base - w_corr;
            w_right = w_base + w_corr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[5]) begin
            r_left  <= clamp_speed(w_left);
            r_right <= clamp_speed(w_right);
        end
    end

    assign o_left_speed  = r_left;
    assign o_right_speed = r_right;
endmodule

@@ rtl/differential_drive_pid_unit.sv @@
// ----------------------------------------------------------------------------
// differential_drive_pid_unit
// Two-mode PID speed controller for a differential drive.
// ----------------------------------------------------------------------------
// Takes control ticks and returns one pair of clamped wheel speeds per tick,
// in order. The datapath is a six-register pipeline (input, error, PID
// terms, gain products, truncated correction, speed result); a tick passes
// through them in that order before its result is presented. The sustained
// rate is one tick per cycle while the output is not stalled. A stalled
// output fills the pipeline bubbles before the input side stops. Each mode's
// integral and last error update in the PID-terms stage, so consecutive ticks
// of the same mode chain correctly with no gap. Gain registers should only be
// written while no tick is in flight.
`include "assert_macros.svh"

module differential_drive_pid_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    pdc_in_if.sink                           i_in,
    pdc_out_if.source                        o_out,
    input  logic                             i_cfg_we,
    input  logic [pdc_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [pdc_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import pdc_pkg::*;

    t_cfg               w_cfg;
    t_pipe_ctl          w_ctl;
    t_terms             w_terms;
    logic               w_in_ready;
    logic [SPEED_W-1:0] w_left_speed;
    logic [SPEED_W-1:0] w_right_speed;

    pdc_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    pdc_pipe_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_out_ready (o_out.ready),
        .o_in_ready  (w_in_ready),
        .o_ctl       (w_ctl)
    );

    pdc_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (w_ctl),
        .i_cfg         (w_cfg),
        .i_op          (i_in.op),
        .i_position    (i_in.position),
        .i_left_count  (i_in.left_count),
        .i_right_count (i_in.right_count),
        .o_terms       (w_terms)
    );

    pdc_back u_back (
        .i_clk         (i_clk),
        .i_ctl         (w_ctl),
        .i_cfg         (w_cfg),
        .i_terms       (w_terms),
        .o_left_speed  (w_left_speed),
        .o_right_speed (w_right_speed)
    );

    assign i_in.ready        = w_in_ready;
    assign o_out.valid       = w_ctl.valid[NUM_STAGES-1];
    assign o_out.left_speed  = w_left_speed;
    assign o_out.right_speed = w_right_speed;

    // a stalled input means every stage, the result register included, is full
    `ASSERT_SAME(a_stall_full, i_clk, i_rst_n,
        (i_in.valid && !i_in.ready), o_out.valid,
        "input stalled with a bubble in the pipeline")
    `ASSERT_NEXT(a_accept_load, i_clk, i_rst_n,
        (i_in.valid && i_in.ready), w_ctl.valid[0],
        "accepted beat not held in input register")
    `ASSERT_NEXT(a_cfg_base, i_clk, i_rst_n,
        (i_cfg_we && i_cfg_idx == IDX_BASE_SPEED),
        (w_cfg.base_speed == $past(i_cfg_data[SPEED_W-1:0])),
        "base speed write lost")
endmodule
